// ----- hw/rtl/wlc_pkg.sv -----
// Shared types, register indexes and reset values of the window lifter controller.
package wlc_pkg;

  localparam int DEF_SEGMENTS = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OPEN_W     = 4;
  localparam int BAR_W      = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIDE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PINCH_HOLD = 2'd3;

  localparam logic [7:0]  RST_DEBOUNCE   = 8'd10;
  localparam logic [15:0] RST_DECIDE     = 16'd500;
  localparam logic [15:0] RST_STEP       = 16'd400;
  localparam logic [15:0] RST_PINCH_HOLD = 16'd5000;

  typedef enum logic [10:0] {
    PH_IDLE        = 11'b000_0000_0001,
    PH_DEB_DOWN    = 11'b000_0000_0010,
    PH_DEB_UP      = 11'b000_0000_0100,
    PH_DECIDE_DOWN = 11'b000_0000_1000,
    PH_DECIDE_UP   = 11'b000_0001_0000,
    PH_MAN_DOWN    = 11'b000_0010_0000,
    PH_AUTO_DOWN   = 11'b000_0100_0000,
    PH_MAN_UP      = 11'b000_1000_0000,
    PH_AUTO_UP     = 11'b001_0000_0000,
    PH_PINCH_OPEN  = 11'b010_0000_0000,
    PH_PINCH_HOLD  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] decide_ticks;
    logic [15:0] step_ticks;
    logic [15:0] pinch_hold_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [OPEN_W-1:0] open_level;
    logic [BAR_W-1:0]  segment_bar;
    logic              moving_down;
    logic              moving_up;
    logic              down_request_active;
    logic              up_request_active;
    logic              pinch_active;
  } result_t;

endpackage

// ----- hw/rtl/wlc_in_if.sv -----
// Input item channel: button and pinch sensor levels for one tick.
interface wlc_in_if;
  logic valid;
  logic ready;
  logic down_pressed;
  logic up_pressed;
  logic pinch_sensed;

  modport source (output valid, output down_pressed, output up_pressed,
                  output pinch_sensed, input ready);
  modport sink (input valid, input down_pressed, input up_pressed,
                input pinch_sensed, output ready);
endinterface

// ----- hw/rtl/wlc_out_if.sv -----
// Result item channel: window level, segment bar and indicators.
interface wlc_out_if;
  logic                       valid;
  logic                       ready;
  logic [wlc_pkg::OPEN_W-1:0] open_level;
  logic [wlc_pkg::BAR_W-1:0]  segment_bar;
  logic                       moving_down;
  logic                       moving_up;
  logic                       down_request_active;
  logic                       up_request_active;
  logic                       pinch_active;

  modport source (output valid, output open_level, output segment_bar,
                  output moving_down, output moving_up, output down_request_active,
                  output up_request_active, output pinch_active, input ready);
  modport sink (input valid, input open_level, input segment_bar,
                input moving_down, input moving_up, input down_request_active,
                input up_request_active, input pinch_active, output ready);
endinterface

// ----- hw/rtl/wlc_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface wlc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wlc_pkg::CFG_IDX_W-1:0]  index;
  logic [wlc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/wlc_cfg.sv -----
// Configuration register file of the window lifter controller.
module wlc_cfg (
  input  logic               clk,
  input  logic               rst,
  wlc_cfg_if.sink            cfg,
  output wlc_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks   <= wlc_pkg::RST_DEBOUNCE;
      regs.decide_ticks     <= wlc_pkg::RST_DECIDE;
      regs.step_ticks       <= wlc_pkg::RST_STEP;
      regs.pinch_hold_ticks <= wlc_pkg::RST_PINCH_HOLD;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        wlc_pkg::REG_DEBOUNCE:   regs.debounce_ticks   <= cfg.data[7:0];
        wlc_pkg::REG_DECIDE:     regs.decide_ticks     <= cfg.data;
        wlc_pkg::REG_STEP:       regs.step_ticks       <= cfg.data;
        wlc_pkg::REG_PINCH_HOLD: regs.pinch_hold_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/wlc_core.sv -----
// Controller state registers, per-tick next-state logic and result decode.
module wlc_core #(
  parameter int SEGMENTS = wlc_pkg::DEF_SEGMENTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               down_pressed,
  input  logic               up_pressed,
  input  logic               pinch_sensed,
  input  wlc_pkg::cfg_regs_t regs,
  output wlc_pkg::result_t   result
);

  localparam int LVL_W = $clog2(SEGMENTS + 1);
  localparam logic [LVL_W-1:0] SEG_LVL = LVL_W'(SEGMENTS);

  wlc_pkg::phase_t  phase, phase_next, ph_a;
  logic [15:0]      tick_count, tick_count_next, tick_inc;
  logic [7:0]       press_count, press_count_next, press_inc;
  logic [LVL_W-1:0] window_level, window_level_next;
  logic             do_edge;
  logic             pinch_case;
  logic [LVL_W+3:0] lvl_ext;

  assign tick_inc   = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign press_inc  = (press_count == 8'hFF) ? press_count : press_count + 8'd1;
  assign pinch_case = pinch_sensed && (phase == wlc_pkg::PH_DECIDE_UP ||
                      phase == wlc_pkg::PH_MAN_UP || phase == wlc_pkg::PH_AUTO_UP);

  always_comb begin
    ph_a              = phase;
    tick_count_next   = tick_count;
    press_count_next  = press_count;
    window_level_next = window_level;
    do_edge           = 1'b0;

    if (pinch_case) begin
      ph_a    = wlc_pkg::PH_PINCH_OPEN;
      do_edge = 1'b1;
    end else begin
      unique case (phase)
        wlc_pkg::PH_DEB_DOWN: begin
          if (down_pressed) begin
            if (press_inc >= regs.debounce_ticks) begin
              ph_a             = wlc_pkg::PH_DECIDE_DOWN;
              tick_count_next  = '0;
              press_count_next = '0;
            end else begin
              press_count_next = press_inc;
            end
          end else begin
            ph_a             = wlc_pkg::PH_IDLE;
            press_count_next = '0;
          end
        end
        wlc_pkg::PH_DEB_UP: begin
          if (up_pressed) begin
            if (press_inc >= regs.debounce_ticks) begin
              ph_a             = wlc_pkg::PH_DECIDE_UP;
              tick_count_next  = '0;
              press_count_next = '0;
            end else begin
              press_count_next = press_inc;
            end
          end else begin
            ph_a             = wlc_pkg::PH_IDLE;
            press_count_next = '0;
          end
        end
        wlc_pkg::PH_DECIDE_DOWN: begin
          tick_count_next = tick_inc;
          if (tick_inc >= regs.decide_ticks) begin
            ph_a    = down_pressed ? wlc_pkg::PH_MAN_DOWN : wlc_pkg::PH_AUTO_DOWN;
            do_edge = 1'b1;
          end
        end
        wlc_pkg::PH_DECIDE_UP: begin
          tick_count_next = tick_inc;
          if (tick_inc >= regs.decide_ticks) begin
            ph_a    = up_pressed ? wlc_pkg::PH_MAN_UP : wlc_pkg::PH_AUTO_UP;
            do_edge = 1'b1;
          end
        end
        wlc_pkg::PH_MAN_DOWN, wlc_pkg::PH_AUTO_DOWN, wlc_pkg::PH_MAN_UP,
        wlc_pkg::PH_AUTO_UP, wlc_pkg::PH_PINCH_OPEN: begin
          tick_count_next = tick_inc;
          do_edge         = (tick_inc >= regs.step_ticks);
        end
        wlc_pkg::PH_PINCH_HOLD: begin
          tick_count_next = tick_inc;
          if (tick_inc >= regs.pinch_hold_ticks) begin
            ph_a            = wlc_pkg::PH_IDLE;
            tick_count_next = '0;
          end
        end
        default: begin
          // idle: down button has priority; the first held tick counts as one
          ph_a             = wlc_pkg::PH_IDLE;
          tick_count_next  = '0;
          press_count_next = '0;
          if (down_pressed || up_pressed) begin
            if (8'd1 >= regs.debounce_ticks) begin
              ph_a = down_pressed ? wlc_pkg::PH_DECIDE_DOWN : wlc_pkg::PH_DECIDE_UP;
            end else begin
              ph_a             = down_pressed ? wlc_pkg::PH_DEB_DOWN : wlc_pkg::PH_DEB_UP;
              press_count_next = 8'd1;
            end
          end
        end
      endcase
    end

    phase_next = ph_a;
    if (do_edge) begin
      tick_count_next = '0;
      unique case (ph_a)
        wlc_pkg::PH_MAN_DOWN, wlc_pkg::PH_AUTO_DOWN: begin
          if ((ph_a == wlc_pkg::PH_MAN_DOWN && !down_pressed) || window_level >= SEG_LVL)
            phase_next = wlc_pkg::PH_IDLE;
          else
            window_level_next = window_level + LVL_W'(1);
        end
        wlc_pkg::PH_MAN_UP, wlc_pkg::PH_AUTO_UP: begin
          if ((ph_a == wlc_pkg::PH_MAN_UP && !up_pressed) || window_level == '0)
            phase_next = wlc_pkg::PH_IDLE;
          else
            window_level_next = window_level - LVL_W'(1);
        end
        wlc_pkg::PH_PINCH_OPEN: begin
          if (window_level >= SEG_LVL)
            phase_next = wlc_pkg::PH_PINCH_HOLD;
          else
            window_level_next = window_level + LVL_W'(1);
        end
        default: phase_next = wlc_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wlc_pkg::PH_IDLE;
      tick_count   <= '0;
      press_count  <= '0;
      window_level <= SEG_LVL;
    end else if (accept) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      press_count  <= press_count_next;
      window_level <= window_level_next;
    end
  end

  // result describes the state after this tick's update
  assign lvl_ext = {4'b0000, window_level_next};

  always_comb begin
    result.open_level = lvl_ext[wlc_pkg::OPEN_W-1:0];
    for (int i = 0; i < wlc_pkg::BAR_W; i++) begin
      result.segment_bar[i] = (i < SEGMENTS) && (lvl_ext <= (LVL_W + 4)'(i));
    end
    result.moving_down = (phase_next == wlc_pkg::PH_MAN_DOWN) ||
                         (phase_next == wlc_pkg::PH_AUTO_DOWN) ||
                         (phase_next == wlc_pkg::PH_PINCH_OPEN);
    result.moving_up = (phase_next == wlc_pkg::PH_MAN_UP) ||
                       (phase_next == wlc_pkg::PH_AUTO_UP);
    result.down_request_active = (phase_next == wlc_pkg::PH_DECIDE_DOWN) ||
                                 (phase_next == wlc_pkg::PH_MAN_DOWN) ||
                                 (phase_next == wlc_pkg::PH_AUTO_DOWN);
    result.pinch_active = (phase_next == wlc_pkg::PH_PINCH_OPEN) ||
                          (phase_next == wlc_pkg::PH_PINCH_HOLD);
    result.up_request_active = (phase_next == wlc_pkg::PH_DECIDE_UP) ||
                               (phase_next == wlc_pkg::PH_MAN_UP) ||
                               (phase_next == wlc_pkg::PH_AUTO_UP) ||
                               result.pinch_active;
  end

endmodule

// ----- hw/rtl/wlc_out_reg.sv -----
// Result register driving the output channel.
module wlc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wlc_pkg::result_t result,
  output logic             can_load,
  wlc_out_if.source        status
);

  logic             valid;
  wlc_pkg::result_t held;

  // the slot frees up in the same cycle the held item is taken
  assign can_load = !valid || status.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (status.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign status.valid               = valid;
  assign status.open_level          = held.open_level;
  assign status.segment_bar         = held.segment_bar;
  assign status.moving_down         = held.moving_down;
  assign status.moving_up           = held.moving_up;
  assign status.down_request_active = held.down_request_active;
  assign status.up_request_active   = held.up_request_active;
  assign status.pinch_active        = held.pinch_active;

endmodule

// ----- hw/rtl/window_lifter_controller_top.sv -----
// Window lifter controller: one tick item in, one status item out.
// The result of an item is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the output register is the only stage, so an item
// is taken whenever that register is empty or is being emptied in the same cycle.
// Reset (rst, synchronous): idle, counters zero, window fully open, timing registers
// at their defaults, no result pending.
module window_lifter_controller_top #(
  parameter int SEGMENTS = wlc_pkg::DEF_SEGMENTS
) (
  input logic       clk,
  input logic       rst,
  wlc_in_if.sink    cmd,
  wlc_out_if.source status,
  wlc_cfg_if.sink   cfg
);

  wlc_pkg::cfg_regs_t regs;
  wlc_pkg::result_t   result;
  logic               can_load;
  logic               accept;

  assign cmd.ready = can_load;
  assign accept    = cmd.valid && can_load;

  wlc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  wlc_core #(
    .SEGMENTS (SEGMENTS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .down_pressed (cmd.down_pressed),
    .up_pressed   (cmd.up_pressed),
    .pinch_sensed (cmd.pinch_sensed),
    .regs         (regs),
    .result       (result)
  );

  wlc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .status   (status)
  );

endmodule
